// ----- sv/bns_pkg.sv -----
// Shared types and constants for the bit store with next-clear search.
`default_nettype none

package bns_pkg;

  localparam int MODE_W = 2;
  localparam int IDX_W  = 12;
  localparam int POS_W  = 13;
  localparam int CFG_W  = 7;
  localparam int WORD_W = 64;
  localparam int OFF_W  = 6;
  localparam int UW     = 7;

  localparam logic [CFG_W-1:0] WIU_RESET = 7'd64;

  localparam logic WIU_REG_IDX = 1'b0;

  localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN
  } bns_state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic first;
    logic adv;
    logic wr;
    logic load_out;
  } bns_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              ok;
    logic              found;
    logic              last;
    logic              out_free;
    logic              clr_last;
  } bns_stat_t;

endpackage

`default_nettype wire

// ----- sv/bns_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface bns_in_if;
  import bns_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  bit_index;

  modport source (output valid, output mode, output bit_index, input ready);
  modport sink (input valid, input mode, input bit_index, output ready);
endinterface

interface bns_out_if;
  import bns_pkg::*;

  logic             valid;
  logic             ready;
  logic             bit_value;
  logic [POS_W-1:0] clear_position;
  logic             start_beyond_end;

  modport source (output valid, output bit_value, output clear_position,
                  output start_beyond_end, input ready);
  modport sink (input valid, input bit_value, input clear_position,
                input start_beyond_end, output ready);
endinterface

`default_nettype wire

// ----- sv/bns_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bns_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/bns_ctrl.sv -----
// Controller state machine: clearing pass, item accept, read, scan, result transfer.
`default_nettype none

module bns_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bns_pkg::bns_stat_t stat,
  output bns_pkg::bns_cmd_t       cmd
);
  import bns_pkg::*;

  bns_state_t state_r, state_nxt;
  logic       done;

  always_comb begin
    done = 1'b0;
    unique case (state_r)
      ST_READ: begin
        case (stat.mode)
          MODE_NEXT: done = !stat.ok || stat.found || stat.last;
          default:   done = 1'b1;
        endcase
      end
      ST_SCAN: done = stat.found || stat.last;
      default: done = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ: begin
        if (done) begin
          if (stat.out_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (done && stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.first    = 1'b1;
        cmd.wr       = stat.ok && (stat.mode == MODE_SET || stat.mode == MODE_CLEAR);
        cmd.adv      = !done;
        cmd.load_out = done && stat.out_free;
      end
      ST_SCAN: begin
        cmd.adv      = !done;
        cmd.load_out = done && stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bns_dpath.sv -----
// Datapath: word store, item registers, word walk, clear-bit encoder, output register.
`default_nettype none

module bns_dpath #(
  parameter int WORD_COUNT = 64,
  parameter int AW         = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bns_pkg::bns_cmd_t          cmd,
  output bns_pkg::bns_stat_t              stat,
  input  wire logic [bns_pkg::MODE_W-1:0] in_mode,
  input  wire logic [bns_pkg::IDX_W-1:0]  in_bit_index,
  input  wire logic [bns_pkg::CFG_W-1:0]  words_in_use,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic                            out_bit_value,
  output logic [bns_pkg::POS_W-1:0]       out_clear_position,
  output logic                            out_start_beyond_end
);
  import bns_pkg::*;

  localparam int CAP = (WORD_COUNT > 127) ? 127 : WORD_COUNT;

  logic [MODE_W-1:0] mode_r;
  logic [OFF_W-1:0]  off_r;
  logic [UW-1:0]     u_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  logic              bit_value_r;
  logic [POS_W-1:0]  clear_position_r;
  logic              beyond_r;

  logic [UW-1:0]     nw;
  logic [UW:0]       u_inc;
  logic              ok;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] inv;
  logic [OFF_W-1:0]  lo;
  logic              found;
  logic              ram_we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic              res_bit;
  logic [POS_W-1:0]  res_pos;
  logic              res_beyond;

  assign nw       = (words_in_use > UW'(CAP)) ? UW'(CAP) : words_in_use;
  assign u_inc    = {1'b0, u_r} + (UW+1)'(1);
  assign ok       = u_r < nw;
  assign bit_mask = WORD_W'(1) << off_r;
  assign inv      = ~rdata & (cmd.first ? ({WORD_W{1'b1}} << off_r) : {WORD_W{1'b1}});
  assign found    = |inv;

  always_comb begin
    lo = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (inv[i]) lo = OFF_W'(i);
    end
  end

  always_comb begin
    if (cmd.accept) begin
      raddr = AW'(in_bit_index[IDX_W-1:OFF_W]);
    end else if (cmd.adv) begin
      raddr = AW'(u_inc[UW-1:0]);
    end else begin
      raddr = AW'(u_r);
    end
  end

  always_comb begin
    ram_we = cmd.wr || cmd.clr_step;
    if (cmd.clr_step) begin
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      waddr = AW'(u_r);
      wdata = (mode_r == MODE_SET) ? (rdata | bit_mask) : (rdata & ~bit_mask);
    end
  end

  bns_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    res_bit    = 1'b0;
    res_pos    = '0;
    res_beyond = 1'b0;
    case (mode_r)
      MODE_GET: res_bit = ok && ((rdata & bit_mask) != '0);
      MODE_NEXT: begin
        if (!ok) begin
          res_beyond = 1'b1;
        end else if (found) begin
          res_pos = {u_r, lo};
        end else begin
          res_pos = {nw, {OFF_W{1'b0}}};
        end
      end
      default: res_bit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      off_r  <= in_bit_index[OFF_W-1:0];
      u_r    <= {1'b0, in_bit_index[IDX_W-1:OFF_W]};
    end else if (cmd.adv) begin
      u_r <= u_inc[UW-1:0];
    end
    if (cmd.load_out) begin
      bit_value_r      <= res_bit;
      clear_position_r <= res_pos;
      beyond_r         <= res_beyond;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.mode     = mode_r;
  assign stat.ok       = ok;
  assign stat.found    = found;
  assign stat.last     = u_inc >= {1'b0, nw};
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.clr_last = clr_cnt_r == AW'(WORD_COUNT - 1);

  assign out_valid            = out_valid_r;
  assign out_bit_value        = bit_value_r;
  assign out_clear_position   = clear_position_r;
  assign out_start_beyond_end = beyond_r;

endmodule

`default_nettype wire

// ----- sv/bitset_with_next_clear_search_unit.sv -----
// Bit store of 64-bit words with set, clear, get and next-clear-bit search.
//
// Items arrive on in_ch (mode, bit_index) and each gives exactly one result
// transfer on out_ch (bit_value, clear_position, start_beyond_end).
// Words in use are set through the APB register at byte address 0.
// One item is worked on at a time. Set, clear and get go from accept to the
// result register through the RAM read and then a step that modifies and
// writes back the word or picks the bit. Next-clear reads one word per cycle
// through the RAM read port, walking on through further words until a clear
// bit is found or the last word in use is reached.
// A result waits in the output register while out_ch is stalled; the next
// item is accepted meanwhile, and its result holds in the datapath until
// the register frees.
// After reset a clearing pass zeroes every word of the store; no item
// is accepted during it, register writes are taken as ever. words_in_use
// resets to 64.
`default_nettype none

module bitset_with_next_clear_search_unit #(
  parameter int WORD_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bns_in_if.sink           in_ch,
  bns_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import bns_pkg::*;

  localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  logic [CFG_W-1:0] words_in_use_r;
  logic             cfg_wr;
  bns_cmd_t         cmd;
  bns_stat_t        stat;
  logic             in_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == WIU_REG_IDX);
  assign prdata = (paddr[2] == WIU_REG_IDX) ? 32'(words_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= WIU_RESET;
    end else if (cfg_wr) begin
      words_in_use_r <= pwdata[CFG_W-1:0];
    end
  end

  bns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  bns_dpath #(
    .WORD_COUNT (WORD_COUNT),
    .AW         (AW)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_mode              (in_ch.mode),
    .in_bit_index         (in_ch.bit_index),
    .words_in_use         (words_in_use_r),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_bit_value        (out_ch.bit_value),
    .out_clear_position   (out_ch.clear_position),
    .out_start_beyond_end (out_ch.start_beyond_end)
  );

endmodule

`default_nettype wire
